// ----- rtl/core/dhcpomg_pkg.sv -----
// shared types and constants for the dhcp option mask and gateway extractor
`timescale 1ns / 1ps
`default_nettype none

package dhcpomg_pkg;

    // default size of the options area in bytes
    localparam int OPTION_AREA_BYTES_DEF = 256;

    // option codes
    localparam logic [7:0] CODE_PAD    = 8'd0;
    localparam logic [7:0] CODE_MASK   = 8'd1;
    localparam logic [7:0] CODE_ROUTER = 8'd3;
    localparam logic [7:0] CODE_END    = 8'd255;

    // value length of an ipv4 address option
    localparam logic [7:0] ADDR_LEN = 8'd4;

    // parse phase, one-hot
    typedef enum logic [3:0] {
        PH_CODE  = 4'b0001,
        PH_LEN   = 4'b0010,
        PH_VALUE = 4'b0100,
        PH_DONE  = 4'b1000
    } t_phase;

    // where the value of the current record goes
    typedef enum logic [1:0] {
        TGT_NONE = 2'd0,
        TGT_MASK = 2'd1,
        TGT_GATE = 2'd2
    } t_target;

    typedef struct packed {
        logic [7:0] opt_byte;
        logic       last_byte;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] subnet_mask;
        logic [31:0] gateway;
        logic        mask_found;
        logic        gateway_found;
        logic        malformed;
    } t_out_beat;

endpackage

`default_nettype wire

// ----- rtl/core/dhcpomg_parse.sv -----
// option record walker: phase tracking, value capture and result forming
`timescale 1ns / 1ps
`default_nettype none

module dhcpomg_parse #(
    parameter int OPTION_AREA_BYTES = dhcpomg_pkg::OPTION_AREA_BYTES_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_beat_valid,
    input  wire dhcpomg_pkg::t_in_beat i_beat,
    output logic                       o_res_valid,
    output dhcpomg_pkg::t_out_beat     o_res
);

    localparam int CNT_W = $clog2(OPTION_AREA_BYTES + 1);

    dhcpomg_pkg::t_phase  r_phase, n_phase;
    dhcpomg_pkg::t_target r_target, n_target;
    logic [7:0]           r_bytes_left, n_bytes_left;
    logic [31:0]          r_value_acc, n_value_acc;
    logic [31:0]          r_mask_shift, n_mask_shift;
    logic [31:0]          r_gate_shift, n_gate_shift;
    logic                 r_mask_seen, n_mask_seen;
    logic                 r_gate_seen, n_gate_seen;
    logic                 r_bad_seen, n_bad_seen;
    logic [CNT_W-1:0]     r_byte_count, n_byte_count;
    logic [7:0]           w_byte;
    logic [7:0]           w_left_dec;
    logic                 w_open;

    assign w_byte     = i_beat.opt_byte;
    assign w_left_dec = r_bytes_left - 8'd1;

    always_comb begin
        n_phase      = r_phase;
        n_target     = r_target;
        n_bytes_left = r_bytes_left;
        n_value_acc  = r_value_acc;
        n_mask_shift = r_mask_shift;
        n_gate_shift = r_gate_shift;
        n_mask_seen  = r_mask_seen;
        n_gate_seen  = r_gate_seen;
        n_bad_seen   = r_bad_seen;
        n_byte_count = r_byte_count;

        // bytes past the area size are ignored
        if (r_byte_count < CNT_W'(OPTION_AREA_BYTES)) begin
            n_byte_count = r_byte_count + CNT_W'(1);
            unique case (r_phase)
                dhcpomg_pkg::PH_CODE: begin
                    if (w_byte == dhcpomg_pkg::CODE_END) begin
                        n_phase = dhcpomg_pkg::PH_DONE;
                    end else if (w_byte != dhcpomg_pkg::CODE_PAD) begin
                        if (w_byte == dhcpomg_pkg::CODE_MASK) begin
                            n_target = dhcpomg_pkg::TGT_MASK;
                        end else if (w_byte == dhcpomg_pkg::CODE_ROUTER) begin
                            n_target = dhcpomg_pkg::TGT_GATE;
                        end else begin
                            n_target = dhcpomg_pkg::TGT_NONE;
                        end
                        n_phase = dhcpomg_pkg::PH_LEN;
                    end
                end
                dhcpomg_pkg::PH_LEN: begin
                    n_bytes_left = w_byte;
                    n_value_acc  = '0;
                    if (r_target != dhcpomg_pkg::TGT_NONE && w_byte != dhcpomg_pkg::ADDR_LEN) begin
                        n_bad_seen = 1'b1;
                        n_target   = dhcpomg_pkg::TGT_NONE;
                    end
                    if (w_byte == 8'd0) begin
                        n_target = dhcpomg_pkg::TGT_NONE;
                        n_phase  = dhcpomg_pkg::PH_CODE;
                    end else begin
                        n_phase = dhcpomg_pkg::PH_VALUE;
                    end
                end
                dhcpomg_pkg::PH_VALUE: begin
                    n_value_acc  = {r_value_acc[23:0], w_byte};
                    n_bytes_left = w_left_dec;
                    if (w_left_dec == 8'd0) begin
                        if (r_target == dhcpomg_pkg::TGT_MASK) begin
                            n_mask_shift = {r_value_acc[23:0], w_byte};
                            n_mask_seen  = 1'b1;
                        end else if (r_target == dhcpomg_pkg::TGT_GATE) begin
                            n_gate_shift = {r_value_acc[23:0], w_byte};
                            n_gate_seen  = 1'b1;
                        end
                        n_target    = dhcpomg_pkg::TGT_NONE;
                        n_value_acc = '0;
                        n_phase     = dhcpomg_pkg::PH_CODE;
                    end
                end
                dhcpomg_pkg::PH_DONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    // a record still open on the last byte is truncated
    assign w_open = (n_phase == dhcpomg_pkg::PH_LEN) || (n_phase == dhcpomg_pkg::PH_VALUE);

    always_comb begin
        o_res_valid         = i_beat_valid && i_beat.last_byte;
        o_res.subnet_mask   = n_mask_seen ? n_mask_shift : 32'd0;
        o_res.gateway       = n_gate_seen ? n_gate_shift : 32'd0;
        o_res.mask_found    = n_mask_seen;
        o_res.gateway_found = n_gate_seen;
        o_res.malformed     = n_bad_seen || w_open;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_beat_valid && i_beat.last_byte)) begin
            r_phase      <= dhcpomg_pkg::PH_CODE;
            r_target     <= dhcpomg_pkg::TGT_NONE;
            r_bytes_left <= '0;
            r_value_acc  <= '0;
            r_mask_shift <= '0;
            r_gate_shift <= '0;
            r_mask_seen  <= 1'b0;
            r_gate_seen  <= 1'b0;
            r_bad_seen   <= 1'b0;
            r_byte_count <= '0;
        end else if (i_beat_valid) begin
            r_phase      <= n_phase;
            r_target     <= n_target;
            r_bytes_left <= n_bytes_left;
            r_value_acc  <= n_value_acc;
            r_mask_shift <= n_mask_shift;
            r_gate_shift <= n_gate_shift;
            r_mask_seen  <= n_mask_seen;
            r_gate_seen  <= n_gate_seen;
            r_bad_seen   <= n_bad_seen;
            r_byte_count <= n_byte_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_count <= CNT_W'(OPTION_AREA_BYTES))
        else $error("byte count past area size");

    a_value_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == dhcpomg_pkg::PH_VALUE |-> r_bytes_left != 8'd0)
        else $error("value phase with no bytes left");

    a_target_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_target != dhcpomg_pkg::TGT_NONE |->
            (r_phase == dhcpomg_pkg::PH_LEN || r_phase == dhcpomg_pkg::PH_VALUE))
        else $error("capture target outside an open record");

    a_last_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_beat_valid && i_beat.last_byte |=>
            r_phase == dhcpomg_pkg::PH_CODE && !r_mask_seen && !r_gate_seen && !r_bad_seen)
        else $error("state not cleared after last byte");

endmodule

`default_nettype wire

// ----- rtl/core/dhcpomg_out.sv -----
// result register with valid and stall toward the consumer
`timescale 1ns / 1ps
`default_nettype none

module dhcpomg_out (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_load,
    input  wire dhcpomg_pkg::t_out_beat i_res,
    input  wire logic                   i_out_stall,
    output logic                        o_out_valid,
    output dhcpomg_pkg::t_out_beat      o_out_beat
);

    logic                   r_valid;
    dhcpomg_pkg::t_out_beat r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_beat <= i_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_beat  = r_beat;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> !(r_valid && i_out_stall))
        else $error("result loaded over a stalled beat");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && i_out_stall |=> r_valid && $stable(r_beat))
        else $error("stalled result lost");

    a_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_beat.mask_found |-> r_beat.subnet_mask == 32'd0)
        else $error("mask nonzero without option");

endmodule

`default_nettype wire

// ----- rtl/core/dhcp_option_mask_gateway_extract.sv -----
// top level of the dhcp option walker that extracts subnet mask and gateway
// path: an accepted last byte passes the input register, then the result register, before its result shows
// throughput: one option byte per cycle while no result is stalled at the output, set by the single-pass record walker
// stall: while a result sits stalled at the output the walker holds, the input
// register takes one more byte if it is empty and then the input channel stalls
// reset: synchronous active low, clears all parse state and both valid flags
`timescale 1ns / 1ps
`default_nettype none

module dhcp_option_mask_gateway_extract #(
    parameter int OPTION_AREA_BYTES = dhcpomg_pkg::OPTION_AREA_BYTES_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // option byte channel
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire dhcpomg_pkg::t_in_beat  i_in_beat,
    // result channel
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output dhcpomg_pkg::t_out_beat      o_out_beat
);

    // input register
    logic                   r_in_valid;
    dhcpomg_pkg::t_in_beat  r_in_beat;

    logic                   w_blocked;
    logic                   w_advance;
    logic                   w_accept;
    logic                   w_res_valid;
    dhcpomg_pkg::t_out_beat w_res;

    // the held beat waits only while a result sits stalled at the output
    assign w_blocked  = o_out_valid && i_out_stall;
    assign w_advance  = r_in_valid && !w_blocked;
    assign o_in_stall = r_in_valid && w_blocked;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_beat <= i_in_beat;
        end
    end

    // record walker, one byte per advancing beat
    dhcpomg_parse #(
        .OPTION_AREA_BYTES(OPTION_AREA_BYTES)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_beat_valid(w_advance),
        .i_beat      (r_in_beat),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // result register, loaded on the beat marked last
    dhcpomg_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_res_valid),
        .i_res      (w_res),
        .i_out_stall(i_out_stall),
        .o_out_valid(o_out_valid),
        .o_out_beat (o_out_beat)
    );

    // the held beat moves on unless the result side is backed up
    a_advance_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !(o_out_valid && i_out_stall) |=> !r_in_valid || $past(w_accept))
        else $error("input beat held without back pressure");

    // a result only follows a beat marked last
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_advance && r_in_beat.last_byte))
        else $error("result without last byte");

    // no new result is formed while one is stalled
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> !w_res_valid)
        else $error("result formed over stalled beat");

endmodule

`default_nettype wire
